// ----- hw/rtl/lcdw_pkg.sv -----
// Shared types, character codes and digit helpers for the LCD field writer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package lcdw_pkg;

  // Request kinds
  localparam logic [1:0] REQ_TEMP = 2'd0;
  localparam logic [1:0] REQ_TIME = 2'd1;
  localparam logic [1:0] REQ_DATE = 2'd2;

  // Display line base addresses (set-DDRAM-address commands)
  localparam logic [7:0] ADDR_TOP    = 8'h80;
  localparam logic [7:0] ADDR_BOTTOM = 8'hC0;
  localparam logic [1:0] ROW_TOP     = 2'd1;

  // Character codes
  localparam logic [7:0] CHAR_ZERO   = 8'd48;
  localparam logic [7:0] CHAR_POINT  = 8'd46;
  localparam logic [7:0] CHAR_DEGREE = 8'd223;
  localparam logic [7:0] CHAR_C      = 8'd67;
  localparam logic [7:0] CHAR_COLON  = 8'd58;
  localparam logic [7:0] CHAR_SLASH  = 8'd47;

  // Register-select codes
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Characters per job and queue sizing
  localparam int JOB_CHARS   = 8;
  localparam int CHAR_IDX_W  = $clog2(JOB_CHARS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] row;
    logic [5:0] col;
    logic [9:0] temp_tenths;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } out_item_t;

  // One drawing job: start address, which characters to draw, and the characters
  typedef struct packed {
    logic [7:0]                 start_addr;
    logic [JOB_CHARS-1:0]       mask;
    logic [JOB_CHARS-1:0][7:0] chars;
  } job_t;

  // Nibble position within one character (address byte, then data byte)
  typedef enum logic [1:0] {
    PH_ADDR_HI = 2'd0,
    PH_ADDR_LO = 2'd1,
    PH_DATA_HI = 2'd2,
    PH_DATA_LO = 2'd3
  } phase_t;

  // Divide by ten through reciprocal multiply; exact for inputs below 1029
  function automatic logic [6:0] div10(input logic [9:0] v);
    logic [17:0] p;
    p = {8'd0, v} * 18'd205;
    return p[17:11];
  endfunction

  // Two ASCII digits: tens modulo ten, then units
  function automatic logic [15:0] two_digits(input logic [6:0] v);
    logic [6:0] q;
    logic [3:0] q4;
    logic [3:0] tens;
    logic [6:0] rem;
    q    = div10({3'd0, v});
    q4   = q[3:0];
    tens = (q4 >= 4'd10) ? (q4 - 4'd10) : q4;
    rem  = 7'(v - ({3'd0, q4} << 3) - ({3'd0, q4} << 1));
    return {8'(CHAR_ZERO + {4'd0, tens}), 8'(CHAR_ZERO + {4'd0, rem[3:0]})};
  endfunction

endpackage

// ----- hw/rtl/lcdw_front.sv -----
// Front end: accepts requests, splits values into digits, checks the shown
// time and date, and hands non-empty drawing jobs to the queue. Uses lcdw_pkg.
module lcdw_front import lcdw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     job_push,
  output job_t     job,
  input  logic     job_full
);

  logic       busy_r, busy_nxt;
  in_item_t   req_r;
  logic [6:0] q1_r;

  logic [4:0] shown_hour_r, shown_hour_nxt;
  logic [5:0] shown_minute_r, shown_minute_nxt;
  logic [5:0] shown_second_r, shown_second_nxt;
  logic [4:0] shown_day_r, shown_day_nxt;
  logic [3:0] shown_month_r, shown_month_nxt;
  logic [6:0] shown_year_r, shown_year_nxt;

  logic       accept;
  logic       done;
  logic       need_push;
  logic [9:0] tenths_full;
  logic [6:0] q2;
  logic [3:0] hund;
  logic [6:0] tens_full;
  logic [15:0] hh, mm, ss, dd, mo, yy;
  logic       hr_chg, mi_chg, se_chg, date_chg;
  logic [7:0] base;

  // Digit extraction for the captured request
  always_comb begin
    tenths_full = 10'(req_r.temp_tenths - ({3'd0, q1_r} << 3) - ({3'd0, q1_r} << 1));
    q2          = div10({3'd0, q1_r});
    hund        = (q2[3:0] >= 4'd10) ? (q2[3:0] - 4'd10) : q2[3:0];
    tens_full   = 7'(q1_r - (q2 << 3) - (q2 << 1));
    hh          = two_digits({2'd0, req_r.hour});
    mm          = two_digits({1'd0, req_r.minute});
    ss          = two_digits({1'd0, req_r.second});
    dd          = two_digits({2'd0, req_r.day});
    mo          = two_digits({3'd0, req_r.month});
    yy          = two_digits(req_r.year);
    hr_chg      = req_r.hour != shown_hour_r;
    mi_chg      = req_r.minute != shown_minute_r;
    se_chg      = req_r.second != shown_second_r;
    date_chg    = (req_r.day != shown_day_r) || (req_r.month != shown_month_r) ||
                  (req_r.year != shown_year_r);
    base        = (req_r.row == ROW_TOP) ? ADDR_TOP : ADDR_BOTTOM;
  end

  // Build the job for the captured request
  always_comb begin
    job.start_addr = 8'(base + {2'd0, req_r.col} - 8'd1);
    job.mask       = '0;
    job.chars      = '0;
    case (req_r.req_type)
      REQ_TEMP: begin
        job.mask     = 8'b0011_1111;
        job.chars[0] = 8'(CHAR_ZERO + {4'd0, hund});
        job.chars[1] = 8'(CHAR_ZERO + {4'd0, tens_full[3:0]});
        job.chars[2] = CHAR_POINT;
        job.chars[3] = 8'(CHAR_ZERO + {4'd0, tenths_full[3:0]});
        job.chars[4] = CHAR_DEGREE;
        job.chars[5] = CHAR_C;
      end
      REQ_TIME: begin
        job.mask     = {se_chg, se_chg, mi_chg, mi_chg, mi_chg, hr_chg, hr_chg, hr_chg};
        job.chars[0] = hh[15:8];
        job.chars[1] = hh[7:0];
        job.chars[2] = CHAR_COLON;
        job.chars[3] = mm[15:8];
        job.chars[4] = mm[7:0];
        job.chars[5] = CHAR_COLON;
        job.chars[6] = ss[15:8];
        job.chars[7] = ss[7:0];
      end
      REQ_DATE: begin
        job.mask     = {JOB_CHARS{date_chg}};
        job.chars[0] = dd[15:8];
        job.chars[1] = dd[7:0];
        job.chars[2] = CHAR_SLASH;
        job.chars[3] = mo[15:8];
        job.chars[4] = mo[7:0];
        job.chars[5] = CHAR_SLASH;
        job.chars[6] = yy[15:8];
        job.chars[7] = yy[7:0];
      end
      default: begin
        job.mask = '0;
      end
    endcase
  end

  // Handshake: drop empty jobs, wait for queue room otherwise
  always_comb begin
    need_push = job.mask != '0;
    done      = busy_r && (!need_push || !job_full);
    job_push  = busy_r && need_push && !job_full;
    in_full   = busy_r && !done;
    accept    = in_push && !in_full;
    busy_nxt  = accept || (busy_r && !done);
  end

  // Advance the shown time and date when a request retires
  always_comb begin
    shown_hour_nxt   = shown_hour_r;
    shown_minute_nxt = shown_minute_r;
    shown_second_nxt = shown_second_r;
    shown_day_nxt    = shown_day_r;
    shown_month_nxt  = shown_month_r;
    shown_year_nxt   = shown_year_r;
    if (done && (req_r.req_type == REQ_TIME)) begin
      shown_hour_nxt   = req_r.hour;
      shown_minute_nxt = req_r.minute;
      shown_second_nxt = req_r.second;
    end
    if (done && (req_r.req_type == REQ_DATE)) begin
      shown_day_nxt   = req_r.day;
      shown_month_nxt = req_r.month;
      shown_year_nxt  = req_r.year;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      shown_hour_r   <= 5'd31;
      shown_minute_r <= 6'd63;
      shown_second_r <= 6'd63;
      shown_day_r    <= 5'd0;
      shown_month_r  <= 4'd0;
      shown_year_r   <= 7'd127;
    end else begin
      busy_r         <= busy_nxt;
      shown_hour_r   <= shown_hour_nxt;
      shown_minute_r <= shown_minute_nxt;
      shown_second_r <= shown_second_nxt;
      shown_day_r    <= shown_day_nxt;
      shown_month_r  <= shown_month_nxt;
      shown_year_r   <= shown_year_nxt;
    end
  end

  // Capture the request and its first tenth-division
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
      q1_r  <= div10(in_item.temp_tenths);
    end
  end

endmodule

// ----- hw/rtl/lcdw_queue.sv -----
// Short job queue between the front and back ends.
// Uses job_t and the queue sizing from lcdw_pkg.
module lcdw_queue import lcdw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  // Occupancy and pointers
  always_comb begin
    full       = count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    empty      = count_r == '0;
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? QUEUE_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QUEUE_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = (QUEUE_AW + 1)'(count_r + {{QUEUE_AW{1'b0}}, do_push}
                                 - {{QUEUE_AW{1'b0}}, do_pop});
    pop_job    = entry_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- hw/rtl/lcdw_back.sv -----
// Back end: walks one job's characters and emits address and data nibbles
// into an output register. Uses job_t, out_item_t and phase_t from lcdw_pkg.
module lcdw_back import lcdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      job,
  input  logic      job_empty,
  output logic      job_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic                       active_r, active_nxt;
  logic [7:0]                 addr_r;
  logic [JOB_CHARS-1:0]       mask_r, mask_nxt;
  logic [JOB_CHARS-1:0][7:0] chars_r;
  phase_t                     phase_r, phase_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_item_r, out_item_nxt;

  logic [CHAR_IDX_W-1:0] idx;
  logic [JOB_CHARS-1:0]  idx_onehot;
  logic [JOB_CHARS-1:0]  rest;
  logic [7:0]            addr;
  logic [7:0]            ch;
  logic                  emit;

  // Pick the lowest character still to draw
  always_comb begin
    idx = '0;
    for (int i = JOB_CHARS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        idx = CHAR_IDX_W'(i);
      end
    end
    idx_onehot = JOB_CHARS'(1) << idx;
    rest       = mask_r & ~idx_onehot;
    addr       = 8'(addr_r + {{(8 - CHAR_IDX_W){1'b0}}, idx});
    ch         = chars_r[idx];
  end

  // Select the nibble for the current phase
  always_comb begin
    emit                    = active_r && (!out_valid_r || out_pop);
    out_item_nxt.last       = (phase_r == PH_DATA_LO) && (rest == '0);
    case (phase_r)
      PH_ADDR_HI: begin
        out_item_nxt.reg_select = RS_CMD;
        out_item_nxt.nibble     = addr[7:4];
      end
      PH_ADDR_LO: begin
        out_item_nxt.reg_select = RS_CMD;
        out_item_nxt.nibble     = addr[3:0];
      end
      PH_DATA_HI: begin
        out_item_nxt.reg_select = RS_DATA;
        out_item_nxt.nibble     = ch[7:4];
      end
      PH_DATA_LO: begin
        out_item_nxt.reg_select = RS_DATA;
        out_item_nxt.nibble     = ch[3:0];
      end
      default: begin
        out_item_nxt.reg_select = RS_CMD;
        out_item_nxt.nibble     = addr[7:4];
      end
    endcase
  end

  // Advance through phases and characters; load the next job when idle
  always_comb begin
    job_pop       = !active_r && !job_empty;
    active_nxt    = active_r;
    mask_nxt      = mask_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (job_pop) begin
      active_nxt = 1'b1;
      mask_nxt   = job.mask;
      phase_nxt  = PH_ADDR_HI;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = phase_t'(2'(phase_r + 2'd1));
      if (phase_r == PH_DATA_LO) begin
        mask_nxt = rest;
        if (rest == '0) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      phase_r     <= PH_ADDR_HI;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Hold job payload and the output nibble
  always_ff @(posedge clk) begin
    if (job_pop) begin
      addr_r  <= job.start_addr;
      chars_r <= job.chars;
    end
    if (emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- hw/rtl/lcd_clock_field_writer.sv -----
// Top level of the LCD field writer: front end, job queue, back end.
// Depends on lcdw_pkg, lcdw_front, lcdw_queue and lcdw_back.
//
// Turns one display request (temperature, time of day or date at a row and
// one-based column) into the 4-bit HD44780 nibble stream: for each character a
// set-address command (0x80 top line, 0xC0 second line, plus column-1, modulo
// 256) followed by the character byte, each byte upper nibble first, with last
// set on the final nibble of the request. The block remembers the last shown
// time and date: a time redraws only the hour, minute or second groups that
// changed, a date redraws only if any part changed; requests that draw nothing
// and request type 3 produce no output. The front end holds each captured
// request in a register (digit split and change check) and passes non-empty
// jobs through a two-entry queue, so it takes a new request every cycle while
// the queue has room. The back end loads a job from the queue, then sends one
// nibble per cycle while the consumer keeps popping, four per character.
module lcd_clock_field_writer import lcdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  job_t front_job;
  job_t back_job;
  logic front_push;
  logic queue_full;
  logic queue_empty;
  logic back_pop;

  // Accept and classify requests
  lcdw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .job_push (front_push),
    .job      (front_job),
    .job_full (queue_full)
  );

  // Buffer jobs between the two sides
  lcdw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .push_job (front_job),
    .full     (queue_full),
    .pop      (back_pop),
    .pop_job  (back_job),
    .empty    (queue_empty)
  );

  // Emit the nibble stream
  lcdw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (back_job),
    .job_empty (queue_empty),
    .job_pop   (back_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for lcd_clock_field_writer: drives display requests,
// predicts the nibble stream and compares every popped nibble in order.
// Depends on lcdw_pkg and the lcd_clock_field_writer RTL.
`timescale 1ns / 1ps

module tb;
  import lcdw_pkg::*;

  // Request type that the block ignores
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 64;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  // Expected nibbles of all accepted requests, oldest first
  out_item_t expected_nibbles[$];
  // Nibbles of the request being predicted
  out_item_t req_nibbles[$];

  // Last time and date on the display, as the block should remember them
  logic [4:0] shown_hour;
  logic [5:0] shown_minute;
  logic [5:0] shown_second;
  logic [4:0] shown_day;
  logic [3:0] shown_month;
  logic [6:0] shown_year;

  // Running clock and calendar for well-formed update sequences
  int tick_h, tick_m, tick_s;
  int cal_d, cal_m, cal_y;

  int  mismatch_count;
  int  nibbles_checked;
  int  temp_reqs, time_reqs, date_reqs, ignored_reqs;
  bit  calm;
  bit  hold_pop;

  lcd_clock_field_writer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // Queue one byte as upper nibble, then lower nibble
  function automatic void put_byte(input logic rs, input logic [7:0] b);
    out_item_t n;
    n.reg_select = rs;
    n.last       = 1'b0;
    n.nibble     = b[7:4];
    req_nibbles.push_back(n);
    n.nibble     = b[3:0];
    req_nibbles.push_back(n);
  endfunction

  // Set-address command, then the character itself
  function automatic void put_char(input logic [1:0] row, input int col, input logic [7:0] ch);
    logic [7:0] addr;
    addr = ((row == ROW_TOP) ? ADDR_TOP : ADDR_BOTTOM) + 8'(col) - 8'd1;
    put_byte(RS_CMD, addr);
    put_byte(RS_DATA, ch);
  endfunction

  function automatic void put_pair(input logic [1:0] row, input int col, input int v);
    put_char(row, col, CHAR_ZERO + 8'((v / 10) % 10));
    put_char(row, col + 1, CHAR_ZERO + 8'(v % 10));
  endfunction

  // Work out the nibbles one request draws and update the shown time and date
  function automatic void predict_lcd_nibbles(input in_item_t it);
    out_item_t n;
    int        c;
    c = it.col;
    req_nibbles.delete();
    case (it.req_type)
      REQ_TEMP: begin
        put_char(it.row, c, CHAR_ZERO + 8'((it.temp_tenths / 100) % 10));
        put_char(it.row, c + 1, CHAR_ZERO + 8'((it.temp_tenths / 10) % 10));
        put_char(it.row, c + 2, CHAR_POINT);
        put_char(it.row, c + 3, CHAR_ZERO + 8'(it.temp_tenths % 10));
        put_char(it.row, c + 4, CHAR_DEGREE);
        put_char(it.row, c + 5, CHAR_C);
      end
      REQ_TIME: begin
        if (it.hour != shown_hour) begin
          put_pair(it.row, c, it.hour);
          put_char(it.row, c + 2, CHAR_COLON);
        end
        if (it.minute != shown_minute) begin
          put_pair(it.row, c + 3, it.minute);
          put_char(it.row, c + 5, CHAR_COLON);
        end
        if (it.second != shown_second)
          put_pair(it.row, c + 6, it.second);
        shown_hour   = it.hour;
        shown_minute = it.minute;
        shown_second = it.second;
      end
      REQ_DATE: begin
        if (it.day != shown_day || it.month != shown_month || it.year != shown_year) begin
          put_pair(it.row, c, it.day);
          put_char(it.row, c + 2, CHAR_SLASH);
          put_pair(it.row, c + 3, it.month);
          put_char(it.row, c + 5, CHAR_SLASH);
          put_pair(it.row, c + 6, it.year);
        end
        shown_day   = it.day;
        shown_month = it.month;
        shown_year  = it.year;
      end
      default: ;
    endcase
    // Flag the final nibble of the request
    if (req_nibbles.size() > 0) begin
      n = req_nibbles.pop_back();
      n.last = 1'b1;
      req_nibbles.push_back(n);
    end
    foreach (req_nibbles[i])
      expected_nibbles.push_back(req_nibbles[i]);
  endfunction

  // Offer one item until accepted, then maybe leave a short gap
  task automatic send_request(input in_item_t it);
    int gap;
    @(negedge clk);
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full !== 1'b0);
    predict_lcd_nibbles(it);
    case (it.req_type)
      REQ_TEMP: temp_reqs++;
      REQ_TIME: time_reqs++;
      REQ_DATE: date_reqs++;
      default:  ignored_reqs++;
    endcase
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Random filler for the fields a request does not use
  function automatic in_item_t make_req(input logic [1:0] kind, input logic [1:0] row,
                                        input logic [5:0] col);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.req_type = kind;
    it.row      = row;
    it.col      = col;
    return it;
  endfunction

  function automatic in_item_t temp_req(input logic [1:0] row, input logic [5:0] col,
                                        input logic [9:0] t);
    in_item_t it;
    it = make_req(REQ_TEMP, row, col);
    it.temp_tenths = t;
    return it;
  endfunction

  function automatic in_item_t time_req(input logic [1:0] row, input logic [5:0] col,
                                        input logic [4:0] h, input logic [5:0] m,
                                        input logic [5:0] s);
    in_item_t it;
    it = make_req(REQ_TIME, row, col);
    it.hour   = h;
    it.minute = m;
    it.second = s;
    return it;
  endfunction

  function automatic in_item_t date_req(input logic [1:0] row, input logic [5:0] col,
                                        input logic [4:0] d, input logic [3:0] m,
                                        input logic [6:0] y);
    in_item_t it;
    it = make_req(REQ_DATE, row, col);
    it.day   = d;
    it.month = m;
    it.year  = y;
    return it;
  endfunction

  // Temperatures at the value extremes and at the edge columns
  task automatic test_temperature();
    send_request(temp_req(2'd1, 6'd1, 10'd0));
    send_request(temp_req(2'd2, 6'd40, 10'd999));
    send_request(temp_req(2'd0, 6'd0, 10'd1023));
    send_request(temp_req(2'd3, 6'd63, 10'd1000));
    send_request(temp_req(2'd1, 6'd63, 10'd512));
  endtask

  // Full draw, no change, then a seconds change, a minutes and seconds change and an hour change
  task automatic test_time_groups();
    send_request(time_req(2'd1, 6'd1, 5'd12, 6'd34, 6'd56));
    send_request(time_req(2'd1, 6'd1, 5'd12, 6'd34, 6'd56));
    send_request(time_req(2'd1, 6'd1, 5'd12, 6'd34, 6'd57));
    send_request(time_req(2'd2, 6'd5, 5'd12, 6'd35, 6'd0));
    send_request(time_req(2'd2, 6'd5, 5'd13, 6'd35, 6'd0));
    send_request(time_req(2'd1, 6'd33, 5'd23, 6'd59, 6'd59));
    send_request(time_req(2'd2, 6'd63, 5'd31, 6'd63, 6'd63));
    send_request(time_req(2'd2, 6'd40, 5'd0, 6'd0, 6'd0));
  endtask

  // First date, repeated date, one-part change and out-of-range parts
  task automatic test_date_change();
    send_request(date_req(2'd1, 6'd1, 5'd31, 4'd12, 7'd99));
    send_request(date_req(2'd1, 6'd1, 5'd31, 4'd12, 7'd99));
    send_request(date_req(2'd2, 6'd33, 5'd31, 4'd12, 7'd0));
    send_request(date_req(2'd2, 6'd40, 5'd1, 4'd1, 7'd0));
    send_request(date_req(2'd0, 6'd0, 5'd31, 4'd15, 7'd127));
  endtask

  // Request type three must draw nothing and leave the state alone
  task automatic test_unknown_request();
    send_request(make_req(REQ_NONE, 2'd1, 6'd1));
    send_request(make_req(REQ_NONE, 2'd2, 6'd40));
    send_request(time_req(2'd1, 6'd1, 5'd0, 6'd0, 6'd1));
  endtask

  // Advance the running clock by a few seconds or by a larger jump
  function automatic void advance_clock();
    int total;
    total = tick_h * 3600 + tick_m * 60 + tick_s;
    total += ($urandom_range(0, 3) == 0) ? $urandom_range(60, 4000) : $urandom_range(0, 3);
    total %= 86400;
    tick_h = total / 3600;
    tick_m = (total / 60) % 60;
    tick_s = total % 60;
  endfunction

  function automatic void advance_calendar();
    if ($urandom_range(0, 2) == 0)
      return;
    cal_d++;
    if (cal_d > 28 || $urandom_range(0, 9) == 0) begin
      cal_d = 1;
      cal_m++;
      if (cal_m > 12) begin
        cal_m = 1;
        cal_y = (cal_y + 1) % 100;
      end
    end
  endfunction

  // Mostly well-formed clock and calendar updates, some noise
  task automatic test_random_mix(input int count);
    in_item_t    it;
    int          sent;
    logic [1:0]  row;
    logic [5:0]  col;
    sent = 0;
    while (sent < count) begin
      row = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
      col = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 40));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          it = temp_req(row, col, ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                             : 10'($urandom_range(0, 999)));
        end
        3, 4, 5, 9: begin
          if ($urandom_range(0, 9) != 9)
            advance_clock();
          it = time_req(row, col, 5'(tick_h), 6'(tick_m), 6'(tick_s));
        end
        6, 7: begin
          advance_calendar();
          it = date_req(row, col, 5'(cal_d), 4'(cal_m), 7'(cal_y));
        end
        default: begin
          it = in_item_t'({$urandom, $urandom});
        end
      endcase
      send_request(it);
      if (it.req_type != REQ_NONE)
        sent++;
    end
  endtask

  // Hold the reader off for a long stretch while requests keep coming
  task automatic test_backpressure();
    @(posedge clk);
    hold_pop = 1'b1;
    fork
      begin
        repeat (LONG_HOLD) @(negedge clk);
        hold_pop = 1'b0;
      end
    join_none
    repeat (10)
      send_request(temp_req(2'($urandom_range(1, 2)), 6'($urandom_range(1, 40)),
                            10'($urandom_range(0, 999))));
  endtask

  // Reader: random stall bursts, long hold on request, none in the tail
  int pop_idle;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_idle = 0;
    end else if (hold_pop) begin
      out_pop <= 1'b0;
    end else if (pop_idle > 0) begin
      out_pop <= 1'b0;
      pop_idle--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_pop <= 1'b0;
      pop_idle = $urandom_range(0, 2);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Compare each popped nibble with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (expected_nibbles.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected nibble rs=%b nib=%h last=%b", $realtime,
                   out_item.reg_select, out_item.nibble, out_item.last);
        mismatch_count++;
      end else begin
        out_item_t want;
        want = expected_nibbles.pop_front();
        nibbles_checked++;
        if (out_item.reg_select !== want.reg_select || out_item.nibble !== want.nibble ||
            out_item.last !== want.last) begin
          if (mismatch_count < 10)
            $display("%0t: nibble mismatch: expected rs=%b nib=%h last=%b, got rs=%b nib=%h last=%b",
                     $realtime, want.reg_select, want.nibble, want.last,
                     out_item.reg_select, out_item.nibble, out_item.last);
          mismatch_count++;
        end
      end
    end
  end

  // Run time limit
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_item      = '0;
    out_pop      = 1'b0;
    calm         = 1'b0;
    hold_pop     = 1'b0;
    mismatch_count  = 0;
    nibbles_checked = 0;
    temp_reqs    = 0;
    time_reqs    = 0;
    date_reqs    = 0;
    ignored_reqs = 0;
    shown_hour   = 5'd31;
    shown_minute = 6'd63;
    shown_second = 6'd63;
    shown_day    = 5'd0;
    shown_month  = 4'd0;
    shown_year   = 7'd127;
    tick_h = 9; tick_m = 58; tick_s = 50;
    cal_d = 27; cal_m = 12; cal_y = 98;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_temperature();
    test_time_groups();
    test_date_change();
    test_unknown_request();
    test_random_mix(150);
    test_backpressure();
    calm = 1'b1;
    test_random_mix(40);

    // Drain, then give the block time to show any stray output
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_nibbles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d temperature, %0d time, %0d date, %0d of unknown type",
             temp_reqs, time_reqs, date_reqs, ignored_reqs);
    $display("Nibbles compared: %0d, mismatches: %0d", nibbles_checked, mismatch_count);
    if (mismatch_count == 0 && expected_nibbles.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lcdw_pkg.sv
hw/rtl/lcdw_front.sv
hw/rtl/lcdw_queue.sv
hw/rtl/lcdw_back.sv
hw/rtl/lcd_clock_field_writer.sv
test/tb.sv
